[hw/rtl/mrb_pkg.sv]
package mrb_pkg;

  // Operation codes carried in the operation field of an input transaction.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_POS     = 2'd1;
  localparam logic [1:0] OP_SEQ     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_RSSI  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_SNR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_RETRY = 2'd2;

  localparam logic signed [15:0] LOST_RSSI_RST  = 16'sh8000;
  localparam logic signed [15:0] LOST_SNR_RST   = 16'sh8000;
  localparam logic [7:0]         LOST_RETRY_RST = 8'hFF;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] rssi_value;
    logic signed [15:0] snr_value;
    logic [7:0]         retry_count;
    logic [15:0]        seq_number;
    logic               frame_lost;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         found_index;
    logic               not_found;
    logic signed [15:0] entry_rssi;
    logic signed [15:0] entry_snr;
    logic [7:0]         entry_retry;
    logic [15:0]        entry_seq;
    logic [5:0]         record_count;
    logic [5:0]         last_written_index;
  } out_item_t;

  // One stored record, as it sits in a memory word.
  typedef struct packed {
    logic [15:0]        seq;
    logic signed [15:0] rssi;
    logic signed [15:0] snr;
    logic [7:0]         retry;
  } record_t;

  // Sentinel codes written in place of the measurements of a lost frame.
  typedef struct packed {
    logic signed [15:0] rssi;
    logic signed [15:0] snr;
    logic [7:0]         retry;
  } lost_codes_t;

endpackage

[hw/rtl/measurement_ring_buffer.sv]
// Ring store of DEPTH link-quality records with position and sequence look-up.
// Input channel (in_valid / in_stall / in_item): one transaction per operation,
// an add, a look-up by age position or a search by sequence number. Every input
// transaction yields exactly one result transaction on the output channel
// (out_valid / out_stall / out_item), in order.
// The result leaves through S_DONE and the output register. An add, an unused code
// or a look-up of an empty store or out-of-range position goes straight to S_DONE;
// a position look-up passes through S_READ first, and a sequence search through
// S_SCAN, which reads one record per cycle from the record memory until it finds
// the key or has read every stored record. One item is in work at a time and
// in_stall is high while it is.
// The output is a register: a new transaction is accepted while a result waits,
// and that transaction's result is held internally until the output frees up.
// A stalled output holds its value.
// The cfg_ port writes the lost-frame sentinel codes; write it only while idle.
// Synchronous reset empties the store (count and pointers to zero) and restores
// the sentinel codes; record contents are not cleared and need no clearing pass.
module measurement_ring_buffer
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  lost_codes_t      lost_r;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  record_t          wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  record_t          rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_r.rssi  <= LOST_RSSI_RST;
      lost_r.snr   <= LOST_SNR_RST;
      lost_r.retry <= LOST_RETRY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LOST_RSSI:  lost_r.rssi  <= cfg_wr_data;
        CFG_LOST_SNR:   lost_r.snr   <= cfg_wr_data;
        CFG_LOST_RETRY: lost_r.retry <= cfg_wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  mrb_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .lost_codes (lost_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  mrb_store #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[hw/rtl/mrb_store.sv]
module mrb_store
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  record_t          wr_data,
  input  logic             rd_en,
  input  logic [PTR_W-1:0] rd_addr,
  output record_t          rd_data
);

  record_t mem [DEPTH];
  record_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/mrb_ctrl.sv]
module mrb_ctrl
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_item,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  lost_codes_t      lost_codes,
  output logic             wr_en,
  output logic [PTR_W-1:0] wr_addr,
  output record_t          wr_data,
  output logic             rd_en,
  output logic [PTR_W-1:0] rd_addr,
  input  record_t          rd_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);
  localparam logic [5:0]       SLOT_NONE = 6'(DEPTH);
  localparam logic [5:0]       SLOT_LAST = 6'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [15:0]      key_r, key_nxt;
  logic [5:0]       res_idx_r, res_idx_nxt;
  logic             res_miss_r, res_miss_nxt;
  record_t          res_rec_r, res_rec_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             out_free;
  logic             pos_hit;
  logic [PTR_W:0]   pos_sum;
  logic [PTR_W-1:0] pos_slot;
  logic [PTR_W-1:0] scan_next;
  logic [5:0]       last_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // The position is below the count whenever it is used, so it fits a slot index
  // and the sum stays below twice the depth.
  assign pos_hit   = CMP_W'(in_item.position) < CMP_W'(cnt_r);
  assign pos_sum   = {1'b0, rp_r} + (PTR_W + 1)'(in_item.position);
  assign pos_slot  = (pos_sum >= DEPTH_X) ? PTR_W'(pos_sum - DEPTH_X) : PTR_W'(pos_sum);
  assign scan_next = next_slot(slot_r);

  assign last_idx  = (cnt_r == '0) ? SLOT_NONE :
                     (wp_r == '0)  ? SLOT_LAST : 6'(wp_r - 1'b1);

  // The store is written only as an add is accepted and read only by a look-up
  // as it is accepted or stalls the input; no read meets a write to its entry.
  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    seen_nxt      = seen_r;
    key_nxt       = key_r;
    res_idx_nxt   = res_idx_r;
    res_miss_nxt  = res_miss_r;
    res_rec_nxt   = res_rec_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = wp_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt    = S_DONE;
          res_idx_nxt  = SLOT_NONE;
          res_miss_nxt = 1'b1;
          res_rec_nxt  = '0;
          case (in_item.operation)
            OP_ADD: begin
              wr_en         = 1'b1;
              wr_data.seq   = in_item.seq_number;
              wr_data.rssi  = in_item.frame_lost ? lost_codes.rssi : in_item.rssi_value;
              wr_data.snr   = in_item.frame_lost ? lost_codes.snr : in_item.snr_value;
              wr_data.retry = in_item.frame_lost ? lost_codes.retry : in_item.retry_count;
              wp_nxt        = next_slot(wp_r);
              res_miss_nxt  = 1'b0;
              if (cnt_r == FULL) begin
                rp_nxt = next_slot(rp_r);
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_POS: begin
              if (pos_hit) begin
                rd_en     = 1'b1;
                rd_addr   = pos_slot;
                slot_nxt  = pos_slot;
                state_nxt = S_READ;
              end
            end
            OP_SEQ: begin
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = rp_r;
                slot_nxt  = rp_r;
                seen_nxt  = CNT_W'(1);
                key_nxt   = in_item.seq_number;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_idx_nxt  = 6'(slot_r);
        res_miss_nxt = 1'b0;
        res_rec_nxt  = rd_data;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        // Read data belongs to slot_r; seen_r counts the records fetched so far.
        if (rd_data.seq == key_r) begin
          res_idx_nxt  = 6'(slot_r);
          res_miss_nxt = 1'b0;
          res_rec_nxt  = rd_data;
          state_nxt    = S_DONE;
        end else if (seen_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_next;
          slot_nxt = scan_next;
          seen_nxt = seen_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt.found_index        = res_idx_r;
          out_nxt.not_found          = res_miss_r;
          out_nxt.entry_rssi         = res_rec_r.rssi;
          out_nxt.entry_snr          = res_rec_r.snr;
          out_nxt.entry_retry        = res_rec_r.retry;
          out_nxt.entry_seq          = res_rec_r.seq;
          out_nxt.record_count       = 6'(cnt_r);
          out_nxt.last_written_index = last_idx;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    seen_r     <= seen_nxt;
    key_r      <= key_nxt;
    res_idx_r  <= res_idx_nxt;
    res_miss_r <= res_miss_nxt;
    res_rec_r  <= res_rec_nxt;
    out_r      <= out_nxt;
  end

endmodule

[hw/rtl/mrb_checker.sv]
module mrb_checker
  import mrb_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  localparam logic [5:0] SLOT_NONE = 6'(DEPTH);
  localparam logic       NARROW    = (DEPTH < 64);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // One item in work at a time: the cycle after acceptance the input is stalled.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // A miss reports no slot and an empty record.
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.not_found |->
      out_item.found_index == SLOT_NONE && out_item.entry_seq == '0 &&
      out_item.entry_retry == '0)
    else $error("miss carries slot or record data");

  // An empty store never finds anything and has no last written slot.
  a_empty_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NARROW && out_item.record_count == '0 |->
      out_item.found_index == SLOT_NONE && out_item.last_written_index == SLOT_NONE)
    else $error("empty store reports a slot");

endmodule

bind measurement_ring_buffer mrb_checker #(.DEPTH(DEPTH)) u_mrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
